// ===== hdl/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_CTRL_BYTE = 3'd1;
    localparam logic [2:0] CAUSE_ENDED     = 3'd2;
    localparam logic [2:0] CAUSE_BAD_ESC   = 3'd3;
    localparam logic [2:0] CAUSE_BAD_HEX   = 3'd4;
    localparam logic [2:0] CAUSE_LONE_HIGH = 3'd5;
    localparam logic [2:0] CAUSE_BAD_LOW   = 3'd6;
    localparam logic [2:0] CAUSE_LONE_LOW  = 3'd7;

    localparam int MAX_RESULTS = 4;

    // results caused by one input item, emitted in order 0..last_idx
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  last_idx;
        logic [1:0]                  kind;
        logic [2:0]                  cause;
    } jsu_group_t;

endpackage

`default_nettype wire

// ===== hdl/jsu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_string;
    logic       end_of_input;

    modport source (output valid, output in_byte, output start_of_string,
                    output end_of_input, input ready);
    modport sink (input valid, input in_byte, input start_of_string,
                  input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] result_kind;
    logic [2:0] error_cause;
    logic       last_of_run;

    modport source (output valid, output out_byte, output result_kind,
                    output error_cause, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input result_kind,
                  input error_cause, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/jsu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    jsu_in_if.sink      item,
    input  wire logic   queue_full,
    output logic        push,
    output jsu_group_t  push_group
);

    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_BODY = 7'b0000010,
        MODE_ESC  = 7'b0000100,
        MODE_HEX1 = 7'b0001000,
        MODE_BSL  = 7'b0010000,
        MODE_U    = 7'b0100000,
        MODE_HEX2 = 7'b1000000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  high_reg, high_next;

    logic        accept;
    logic [7:0]  b;
    logic [4:0]  digit;
    logic [8:0]  esc;
    logic [15:0] unit;
    logic [20:0] pair_cp;

    // 0..15 for a hex digit, bit 4 set otherwise
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        else
            v = 5'h10;
        return v;
    endfunction

    // bit 8 set for a byte that is no single-character escape (u included)
    function automatic logic [8:0] esc_val(input logic [7:0] c);
        logic [8:0] v;
        unique case (c)
            8'h22:   v = 9'h022;
            8'h5C:   v = 9'h05C;
            8'h2F:   v = 9'h02F;
            8'h62:   v = 9'h008;
            8'h66:   v = 9'h00C;
            8'h6E:   v = 9'h00A;
            8'h72:   v = 9'h00D;
            8'h74:   v = 9'h009;
            default: v = 9'h100;
        endcase
        return v;
    endfunction

    function automatic jsu_group_t utf8(input logic [20:0] cp);
        jsu_group_t g;
        g = '0;
        g.kind  = KIND_DATA;
        g.cause = CAUSE_NONE;
        if (cp[20:7] == '0)
        begin
            g.bytes[0] = {1'b0, cp[6:0]};
            g.last_idx = 2'd0;
        end
        else if (cp[20:11] == '0)
        begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.last_idx = 2'd1;
        end
        else if (cp[20:16] == '0)
        begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.last_idx = 2'd2;
        end
        else
        begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.last_idx = 2'd3;
        end
        return g;
    endfunction

    function automatic jsu_group_t single(input logic [7:0] v, input logic [1:0] k,
                                          input logic [2:0] c);
        jsu_group_t g;
        g = '0;
        g.bytes[0] = v;
        g.kind     = k;
        g.cause    = c;
        g.last_idx = 2'd0;
        return g;
    endfunction

    assign item.ready = !queue_full;
    assign accept     = item.valid && !queue_full;
    assign b          = item.in_byte;
    assign digit      = hex_val(b);
    assign esc        = esc_val(b);
    assign unit       = {acc_reg, digit[3:0]};
    assign pair_cp    = 21'h010000 + {1'b0, high_reg, unit[9:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        high_next  = high_reg;
        push       = 1'b0;
        push_group = single(8'h00, KIND_DATA, CAUSE_NONE);
        if (accept)
        begin
            if (item.end_of_input)
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    mode_next  = MODE_IDLE;
                    cnt_next   = '0;
                    acc_next   = '0;
                    push       = 1'b1;
                    push_group = single(8'h00, KIND_ERR, CAUSE_ENDED);
                end
            end
            else if (item.start_of_string)
            begin
                mode_next = MODE_BODY;
                cnt_next  = '0;
                acc_next  = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_BODY:
                    begin
                        push = 1'b1;
                        if (b == 8'h22)
                        begin
                            mode_next  = MODE_IDLE;
                            push_group = single(8'h00, KIND_DONE, CAUSE_NONE);
                        end
                        else if (b == 8'h5C)
                        begin
                            mode_next = MODE_ESC;
                            push      = 1'b0;
                        end
                        else if (b < 8'h20)
                        begin
                            mode_next  = MODE_IDLE;
                            cnt_next   = '0;
                            acc_next   = '0;
                            push_group = single(8'h00, KIND_ERR, CAUSE_CTRL_BYTE);
                        end
                        else
                            push_group = single(b, KIND_DATA, CAUSE_NONE);
                    end
                    MODE_ESC:
                    begin
                        if (b == 8'h75)
                        begin
                            mode_next = MODE_HEX1;
                            cnt_next  = '0;
                            acc_next  = '0;
                        end
                        else if (esc[8])
                        begin
                            mode_next  = MODE_IDLE;
                            cnt_next   = '0;
                            acc_next   = '0;
                            push       = 1'b1;
                            push_group = single(8'h00, KIND_ERR, CAUSE_BAD_ESC);
                        end
                        else
                        begin
                            mode_next  = MODE_BODY;
                            push       = 1'b1;
                            push_group = single(esc[7:0], KIND_DATA, CAUSE_NONE);
                        end
                    end
                    MODE_HEX1, MODE_HEX2:
                    begin
                        if (digit[4])
                        begin
                            mode_next  = MODE_IDLE;
                            cnt_next   = '0;
                            acc_next   = '0;
                            push       = 1'b1;
                            push_group = single(8'h00, KIND_ERR, CAUSE_BAD_HEX);
                        end
                        else if (cnt_reg != 2'd3)
                        begin
                            acc_next = {acc_reg[7:0], digit[3:0]};
                            cnt_next = cnt_reg + 2'd1;
                        end
                        else
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (mode_reg == MODE_HEX1)
                            begin
                                if (unit[15:10] == 6'b110110)
                                begin
                                    high_next = unit[9:0];
                                    mode_next = MODE_BSL;
                                end
                                else if (unit[15:10] == 6'b110111)
                                begin
                                    mode_next  = MODE_IDLE;
                                    push       = 1'b1;
                                    push_group = single(8'h00, KIND_ERR, CAUSE_LONE_LOW);
                                end
                                else
                                begin
                                    mode_next  = MODE_BODY;
                                    push       = 1'b1;
                                    push_group = utf8({5'd0, unit});
                                end
                            end
                            else if (unit[15:10] != 6'b110111)
                            begin
                                mode_next  = MODE_IDLE;
                                push       = 1'b1;
                                push_group = single(8'h00, KIND_ERR, CAUSE_BAD_LOW);
                            end
                            else
                            begin
                                mode_next  = MODE_BODY;
                                push       = 1'b1;
                                push_group = utf8(pair_cp);
                            end
                        end
                    end
                    MODE_BSL, MODE_U:
                    begin
                        if ((mode_reg == MODE_BSL && b != 8'h5C) ||
                            (mode_reg == MODE_U && b != 8'h75))
                        begin
                            mode_next  = MODE_IDLE;
                            cnt_next   = '0;
                            acc_next   = '0;
                            push       = 1'b1;
                            push_group = single(8'h00, KIND_ERR, CAUSE_LONE_HIGH);
                        end
                        else if (mode_reg == MODE_BSL)
                            mode_next = MODE_U;
                        else
                        begin
                            mode_next = MODE_HEX2;
                            cnt_next  = '0;
                            acc_next  = '0;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            high_reg <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jsu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire jsu_group_t  push_group,
    input  wire logic        pop,
    output logic             full,
    output logic             empty,
    output jsu_group_t       head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_group_t         entries [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = entries[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jsu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire jsu_group_t  head,
    output logic             pop,
    jsu_out_if.source        result
);

    logic [1:0] idx_reg, idx_next;
    logic       is_last;
    logic       xfer;

    assign is_last = (idx_reg == head.last_idx);
    assign xfer    = result.valid && result.ready;
    assign pop     = xfer && is_last;

    assign result.valid       = !empty;
    assign result.out_byte    = head.bytes[idx_reg];
    assign result.result_kind = head.kind;
    assign result.error_cause = head.cause;
    assign result.last_of_run = is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// ===== hdl/json_string_unescape_utf8.sv =====
// an item's results are registered in the group queue and offered from its head
// throughput: one input item per cycle while the queue is not full; one result per
//   cycle on the output while ready is high, so a group of n bytes takes n transfers
// a group queue of QUEUE_DEPTH entries lets input and output stall apart
// reset (rst_n, async, active low) empties the queue and idles the decoder
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    jsu_in_if.sink      item,
    jsu_out_if.source   result
);

    logic       push;
    jsu_group_t push_group;
    logic       full;
    logic       empty;
    logic       pop;
    jsu_group_t head;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .queue_full (full),
        .push       (push),
        .push_group (push_group)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    jsu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== dv/jsu_decode_check.sv =====
`timescale 1ns / 1ps

module jsu_decode_check
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jsu_in_if           item_ch,
    jsu_out_if          result_ch,
    output int unsigned mismatches,
    output int unsigned awaited
);

    typedef enum logic [2:0] {
        DM_IDLE, DM_BODY, DM_ESC, DM_HEX1, DM_BSL, DM_U, DM_HEX2
    } decode_mode_e;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [2:0] error_cause;
        logic       last_of_run;
    } decoded_t;

    localparam logic [15:0] HIGH_SURR = 16'hD800;
    localparam logic [15:0] LOW_SURR  = 16'hDC00;
    localparam logic [15:0] SURR_END  = 16'hE000;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    decode_mode_e mode      = DM_IDLE;
    logic [1:0]   digit_cnt = '0;
    logic [15:0]  hex_acc   = '0;
    logic [9:0]   high_bits = '0;
    decoded_t     decoded_q[$];
    int           group_len;

    task automatic push_result(input logic [7:0] b, input logic [1:0] kind,
                               input logic [2:0] cause);
        decoded_t r;
        r.out_byte    = b;
        r.result_kind = kind;
        r.error_cause = cause;
        r.last_of_run = 1'b0;
        decoded_q.push_back(r);
        group_len++;
    endtask

    task automatic decode_error(input logic [2:0] cause);
        mode      = DM_IDLE;
        digit_cnt = '0;
        hex_acc   = '0;
        push_result(8'h00, KIND_ERR, cause);
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_result(cp[7:0], KIND_DATA, CAUSE_NONE);
        end
        else if (cp < 21'h800) begin
            push_result({3'b110, cp[10:6]}, KIND_DATA, CAUSE_NONE);
            push_result({2'b10, cp[5:0]}, KIND_DATA, CAUSE_NONE);
        end
        else if (cp < SUPP_BASE) begin
            push_result({4'b1110, cp[15:12]}, KIND_DATA, CAUSE_NONE);
            push_result({2'b10, cp[11:6]}, KIND_DATA, CAUSE_NONE);
            push_result({2'b10, cp[5:0]}, KIND_DATA, CAUSE_NONE);
        end
        else begin
            push_result({5'b11110, cp[20:18]}, KIND_DATA, CAUSE_NONE);
            push_result({2'b10, cp[17:12]}, KIND_DATA, CAUSE_NONE);
            push_result({2'b10, cp[11:6]}, KIND_DATA, CAUSE_NONE);
            push_result({2'b10, cp[5:0]}, KIND_DATA, CAUSE_NONE);
        end
    endtask

    task automatic take_hex(input logic [7:0] b);
        logic [3:0]  nib;
        logic        ok;
        logic [15:0] unit;
        ok  = 1'b1;
        nib = '0;
        if (b >= "0" && b <= "9")
            nib = 4'(b - "0");
        else if (b >= "a" && b <= "f")
            nib = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F")
            nib = 4'(b - "A" + 8'd10);
        else
            ok = 1'b0;

        if (!ok) begin
            decode_error(CAUSE_BAD_HEX);
        end
        else if (digit_cnt != 2'd3) begin
            hex_acc   = {hex_acc[11:0], nib};
            digit_cnt = digit_cnt + 2'd1;
        end
        else begin
            unit      = {hex_acc[11:0], nib};
            hex_acc   = '0;
            digit_cnt = '0;
            if (mode == DM_HEX1) begin
                if (unit >= HIGH_SURR && unit < LOW_SURR) begin
                    high_bits = unit[9:0];
                    mode      = DM_BSL;
                end
                else if (unit >= LOW_SURR && unit < SURR_END) begin
                    decode_error(CAUSE_LONE_LOW);
                end
                else begin
                    mode = DM_BODY;
                    emit_utf8({5'd0, unit});
                end
            end
            else if (unit < LOW_SURR || unit >= SURR_END) begin
                decode_error(CAUSE_BAD_LOW);
            end
            else begin
                mode = DM_BODY;
                emit_utf8(SUPP_BASE + {1'b0, high_bits, unit[9:0]});
            end
        end
    endtask

    task automatic decode_item(input logic [7:0] b, input logic s, input logic e);
        decoded_t tail;
        group_len = 0;
        if (e) begin
            if (mode != DM_IDLE)
                decode_error(CAUSE_ENDED);
        end
        else if (s) begin
            mode      = DM_BODY;
            digit_cnt = '0;
            hex_acc   = '0;
        end
        else begin
            case (mode)
                DM_BODY:
                begin
                    if (b == "\"") begin
                        mode = DM_IDLE;
                        push_result(8'h00, KIND_DONE, CAUSE_NONE);
                    end
                    else if (b == "\\")
                        mode = DM_ESC;
                    else if (b < 8'h20)
                        decode_error(CAUSE_CTRL_BYTE);
                    else
                        push_result(b, KIND_DATA, CAUSE_NONE);
                end
                DM_ESC:
                begin
                    mode = DM_BODY;
                    case (b)
                        "u":
                        begin
                            mode      = DM_HEX1;
                            digit_cnt = '0;
                            hex_acc   = '0;
                        end
                        "\"", "\\", "/": push_result(b, KIND_DATA, CAUSE_NONE);
                        "b": push_result(8'h08, KIND_DATA, CAUSE_NONE);
                        "f": push_result(8'h0C, KIND_DATA, CAUSE_NONE);
                        "n": push_result(8'h0A, KIND_DATA, CAUSE_NONE);
                        "r": push_result(8'h0D, KIND_DATA, CAUSE_NONE);
                        "t": push_result(8'h09, KIND_DATA, CAUSE_NONE);
                        default: decode_error(CAUSE_BAD_ESC);
                    endcase
                end
                DM_HEX1, DM_HEX2: take_hex(b);
                DM_BSL:
                begin
                    if (b != "\\")
                        decode_error(CAUSE_LONE_HIGH);
                    else
                        mode = DM_U;
                end
                DM_U:
                begin
                    if (b != "u") begin
                        decode_error(CAUSE_LONE_HIGH);
                    end
                    else begin
                        mode      = DM_HEX2;
                        digit_cnt = '0;
                        hex_acc   = '0;
                    end
                end
                default: ;
            endcase
        end
        if (group_len > 0) begin
            tail = decoded_q.pop_back();
            tail.last_of_run = 1'b1;
            decoded_q.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        decoded_t want;
        if (!rst_n) begin
            mode       = DM_IDLE;
            digit_cnt  = '0;
            hex_acc    = '0;
            high_bits  = '0;
            mismatches = 0;
            decoded_q.delete();
            awaited    = 0;
        end
        else begin
            if (result_ch.valid && result_ch.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result with nothing pending: out_byte %0h kind %0d cause %0d",
                           result_ch.out_byte, result_ch.result_kind,
                           result_ch.error_cause);
                    mismatches++;
                end
                else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.out_byte, result_ch.out_byte);
                    check_field("result_kind", 8'(want.result_kind), 8'(result_ch.result_kind));
                    check_field("error_cause", 8'(want.error_cause), 8'(result_ch.error_cause));
                    check_field("last_of_run", 8'(want.last_of_run), 8'(result_ch.last_of_run));
                end
            end
            if (item_ch.valid && item_ch.ready)
                decode_item(item_ch.in_byte, item_ch.start_of_string, item_ch.end_of_input);
            awaited = decoded_q.size();
        end
    end

endmodule

// ===== dv/tb_json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_ITEMS    = 500;
    localparam int HOLD_OFF_CYCLES = 150;

    localparam logic [7:0]  QUOTE     = "\"";
    localparam logic [7:0]  BSLASH    = "\\";
    localparam logic [7:0]  LETTER_U  = "u";
    localparam logic [15:0] HIGH_SURR = 16'hD800;
    localparam logic [15:0] LOW_SURR  = 16'hDC00;
    localparam logic [15:0] SURR_END  = 16'hE000;
    localparam logic [7:0]  ESC_LETTERS [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned mismatches;
    int unsigned awaited;
    int          send_idle_pct  = 28;
    int          recv_idle_pct  = 80;
    int          hold_off_req   = 0;
    int          items_done     = 0;
    int          stall_cycles   = 0;
    bit          pressure_done  = 1'b0;

    jsu_in_if  item_ch();
    jsu_out_if result_ch();

    json_string_unescape_utf8 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    jsu_decode_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .result_ch  (result_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver
    initial begin
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_req != 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold_off_req) @(posedge clk);
                hold_off_req = 0;
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send(input logic [7:0] b, input logic s, input logic e,
                        input bit counted = 1'b1);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.in_byte         <= b;
        item_ch.start_of_string <= s;
        item_ch.end_of_input    <= e;
        @(negedge clk);
        while (!item_ch.ready) @(negedge clk);
        @(posedge clk);
        if (counted)
            items_done++;
    endtask

    task automatic send_hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            send("0" + 8'(nib), 1'b0, 1'b0);
        else if ($urandom_range(0, 1))
            send("a" + 8'(nib) - 8'd10, 1'b0, 1'b0);
        else
            send("A" + 8'(nib) - 8'd10, 1'b0, 1'b0);
    endtask

    task automatic send_unit(input logic [15:0] u);
        send(BSLASH, 1'b0, 1'b0);
        send(LETTER_U, 1'b0, 1'b0);
        for (int i = 3; i >= 0; i--)
            send_hex_digit(u[4*i +: 4]);
    endtask

    function automatic logic [15:0] random_bmp();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            default:
            begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= HIGH_SURR && v < SURR_END)
                    v = v ^ 16'h4000;
            end
        endcase
        return v;
    endfunction

    task automatic random_string();
        int          segs;
        logic [7:0]  b;
        logic [15:0] u;
        send(QUOTE, 1'b1, 1'b0);
        segs = $urandom_range(0, 10);
        for (int i = 0; i < segs; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    do b = 8'($urandom_range(8'h20, 8'hFF));
                    while (b == QUOTE || b == BSLASH);
                    send(b, 1'b0, 1'b0);
                end
                4, 5:
                begin
                    send(BSLASH, 1'b0, 1'b0);
                    send(ESC_LETTERS[$urandom_range(0, 7)], 1'b0, 1'b0);
                end
                6, 7: send_unit(random_bmp());
                default:
                begin
                    send_unit(HIGH_SURR | 16'($urandom_range(0, 16'h3FF)));
                    send_unit(LOW_SURR | 16'($urandom_range(0, 16'h3FF)));
                end
            endcase
        end

        if ($urandom_range(0, 99) >= 25) begin
            send(QUOTE, 1'b0, 1'b0);
        end
        else begin
            case ($urandom_range(0, 8))
                0: send(8'($urandom_range(0, 8'h1F)), 1'b0, 1'b0);
                1: send(8'($urandom), 1'($urandom), 1'b1);
                2:
                begin
                    send(BSLASH, 1'b0, 1'b0);
                    do b = 8'($urandom);
                    while (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
                    send(b, 1'b0, 1'b0);
                end
                3:
                begin
                    // bad digit in the first or the second unit
                    if ($urandom_range(0, 1))
                        send_unit(HIGH_SURR | 16'($urandom_range(0, 16'h3FF)));
                    send(BSLASH, 1'b0, 1'b0);
                    send(LETTER_U, 1'b0, 1'b0);
                    repeat ($urandom_range(0, 3)) send_hex_digit(4'($urandom));
                    do b = 8'($urandom);
                    while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
                    send(b, 1'b0, 1'b0);
                end
                4:
                begin
                    send_unit(HIGH_SURR | 16'($urandom_range(0, 16'h3FF)));
                    if ($urandom_range(0, 1)) begin
                        send(BSLASH, 1'b0, 1'b0);
                        do b = 8'($urandom);
                        while (b == LETTER_U);
                    end
                    else begin
                        do b = 8'($urandom);
                        while (b == BSLASH);
                    end
                    send(b, 1'b0, 1'b0);
                end
                5:
                begin
                    send_unit(HIGH_SURR | 16'($urandom_range(0, 16'h3FF)));
                    do u = 16'($urandom);
                    while (u >= LOW_SURR && u < SURR_END);
                    send_unit(u);
                end
                6: send_unit(LOW_SURR | 16'($urandom_range(0, 16'h3FF)));
                7:
                begin
                    // source runs out inside an escape or a hex unit
                    send(BSLASH, 1'b0, 1'b0);
                    if ($urandom_range(0, 1)) begin
                        send(LETTER_U, 1'b0, 1'b0);
                        repeat ($urandom_range(0, 3)) send_hex_digit(4'($urandom));
                    end
                    send(8'($urandom), 1'($urandom), 1'b1);
                end
                default: ; // left open, the next start drops it
            endcase
        end

        if ($urandom_range(0, 7) == 0)
            send(8'($urandom), 1'b0, 1'($urandom), 1'b0);
    endtask

    initial begin
        item_ch.valid           = 1'b0;
        item_ch.in_byte         = 8'h00;
        item_ch.start_of_string = 1'b0;
        item_ch.end_of_input    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send(8'hFF, 1'b1, 1'b1);
        send(8'h00, 1'b0, 1'b0);
        send(QUOTE, 1'b1, 1'b0);
        send(8'hFF, 1'b0, 1'b0);
        send(8'h20, 1'b0, 1'b0);
        send_unit(16'h0000);
        send(QUOTE, 1'b1, 1'b0);
        send_unit(16'hDBFF);
        send_unit(16'hDFFF);
        send(QUOTE, 1'b0, 1'b0);
        send(QUOTE, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b1);

        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            if (items_done >= RANDOM_ITEMS / 3 && items_done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 28;
            end
            else if (items_done >= 2 * RANDOM_ITEMS / 3 && !pressure_done) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off_req  = HOLD_OFF_CYCLES;
                pressure_done = 1'b1;
            end
            random_string();
        end
        item_ch.valid <= 1'b0;

        @(negedge clk);
        while (awaited != 0) @(negedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
